// ----- sv/nearest_palette_color_assert.svh -----
// Assertion macros for the nearest palette color block.
// Included by the checker module; depends on a clock named aclk and reset aresetn.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nearest_palette_color assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nearest_palette_color assertion failed");

`endif

// ----- sv/npc_pkg.sv -----
// Shared types, constants and the palette ROM of the nearest palette color block.
// No dependencies.
package npc_pkg;

    localparam int ROM_SLOTS               = 128;
    localparam int PALETTE_ENTRIES_DEFAULT = 80;
    localparam int IDX_W                   = 7;
    localparam int DIST_W                  = 18;
    localparam int BYTE_W                  = 8;

    // Above every reachable distance (the largest is 195075).
    localparam logic [DIST_W-1:0] DIST_PAD = '1;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sq_dist;
    } cand_t;

    // The later candidate replaces the earlier one only when strictly closer.
    function automatic cand_t pick_closer(input cand_t lo, input cand_t hi);
        pick_closer = (hi.sq_dist < lo.sq_dist) ? hi : lo;
    endfunction

    function automatic logic [BYTE_W-1:0] abs_diff(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Palette as packed 0xRRGGBB; slots past the listed entries are black.
    function automatic logic [23:0] palette_rgb(input logic [IDX_W-1:0] slot);
        unique case (slot)
            7'd0:  palette_rgb = 24'h020406;
            7'd1:  palette_rgb = 24'h223060;
            7'd2:  palette_rgb = 24'h862a5a;
            7'd3:  palette_rgb = 24'h048c5a;
            7'd4:  palette_rgb = 24'hb0583c;
            7'd5:  palette_rgb = 24'h645c54;
            7'd6:  palette_rgb = 24'hc8cace;
            7'd7:  palette_rgb = 24'hfff4ec;
            7'd8:  palette_rgb = 24'hff0c5a;
            7'd9:  palette_rgb = 24'hffa80c;
            7'd10: palette_rgb = 24'hffee30;
            7'd11: palette_rgb = 24'h0ce840;
            7'd12: palette_rgb = 24'h30b4ff;
            7'd13: palette_rgb = 24'h8a7ca4;
            7'd14: palette_rgb = 24'hff7eb0;
            7'd15: palette_rgb = 24'hffd2b0;
            7'd16: palette_rgb = 24'h2e1c18;
            7'd17: palette_rgb = 24'h16243c;
            7'd18: palette_rgb = 24'h48263c;
            7'd19: palette_rgb = 24'h185a60;
            7'd20: palette_rgb = 24'h7c3630;
            7'd21: palette_rgb = 24'h503a42;
            7'd22: palette_rgb = 24'ha88e80;
            7'd23: palette_rgb = 24'hf6f288;
            7'd24: palette_rgb = 24'hc61a5c;
            7'd25: palette_rgb = 24'hff742c;
            7'd26: palette_rgb = 24'hb0ec38;
            7'd27: palette_rgb = 24'h04bc50;
            7'd28: palette_rgb = 24'h0c60be;
            7'd29: palette_rgb = 24'h7c4e6e;
            7'd30: palette_rgb = 24'hff7860;
            7'd31: palette_rgb = 24'hffa48c;
            7'd32: palette_rgb = 24'hd0d058;
            7'd33: palette_rgb = 24'ha0a840;
            7'd34: palette_rgb = 24'h708028;
            7'd35: palette_rgb = 24'h405010;
            7'd36: palette_rgb = 24'h332c50;
            7'd37: palette_rgb = 24'h46878f;
            7'd38: palette_rgb = 24'h94e344;
            7'd39: palette_rgb = 24'he2f3e4;
            7'd40: palette_rgb = 24'h211e20;
            7'd41: palette_rgb = 24'h555568;
            7'd42: palette_rgb = 24'ha0a08b;
            7'd43: palette_rgb = 24'he9efec;
            7'd44: palette_rgb = 24'h7c3f58;
            7'd45: palette_rgb = 24'heb6b6f;
            7'd46: palette_rgb = 24'hf9a875;
            7'd47: palette_rgb = 24'hfff6d3;
            7'd48: palette_rgb = 24'hc2c630;
            7'd49: palette_rgb = 24'h3fa130;
            7'd50: palette_rgb = 24'h4e5817;
            7'd51: palette_rgb = 24'h342b19;
            7'd52: palette_rgb = 24'hffd37b;
            7'd53: palette_rgb = 24'he18734;
            7'd54: palette_rgb = 24'hc34e29;
            7'd55: palette_rgb = 24'h634805;
            7'd56: palette_rgb = 24'hc13d95;
            7'd57: palette_rgb = 24'h8d1523;
            7'd58: palette_rgb = 24'hffffff;
            7'd59: palette_rgb = 24'hadadcb;
            7'd60: palette_rgb = 24'h596e78;
            7'd61: palette_rgb = 24'h72b3ff;
            7'd62: palette_rgb = 24'h3d65b6;
            7'd63: palette_rgb = 24'h244449;
            7'd64: palette_rgb = 24'h2b120d;
            7'd65: palette_rgb = 24'h9f1211;
            7'd66: palette_rgb = 24'hfc1400;
            7'd67: palette_rgb = 24'hfc6a00;
            7'd68: palette_rgb = 24'hfcfc00;
            7'd69: palette_rgb = 24'h9c0c9c;
            7'd70: palette_rgb = 24'hff099d;
            7'd71: palette_rgb = 24'h00072c;
            7'd72: palette_rgb = 24'h0000ff;
            7'd73: palette_rgb = 24'h67cdfc;
            7'd74: palette_rgb = 24'h004849;
            7'd75: palette_rgb = 24'h00c908;
            7'd76: palette_rgb = 24'h52ff00;
            7'd77: palette_rgb = 24'had5950;
            7'd78: palette_rgb = 24'hfcb448;
            7'd79: palette_rgb = 24'hddd9e6;
            default: palette_rgb = 24'h000000;
        endcase
    endfunction

endpackage

// ----- sv/nearest_palette_color.sv -----
// Nearest palette color: maps each ARGB pixel to the index of the closest palette entry
// by squared RGB distance, lowest index on ties; alpha is ignored. One pixel is taken
// every clock unless back-pressure stalls the pipeline: one stage computes
// all 128 slot distances, then four registered stages of a pairwise compare tree
// (128 to 32 to 8 to 2 to 1) pick the minimum. Every stage stalls only when its
// successor is full, so back-pressure on the result side holds up to five requests.
module nearest_palette_color
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_pixel_argb,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_palette_index
);

    localparam int N1 = ROM_SLOTS;
    localparam int N2 = N1 / 4;
    localparam int N3 = N2 / 4;
    localparam int N4 = N3 / 4;

    logic  v1, v2, v3, v4;
    logic  r1, r2, r3, r4;
    cand_t c1 [N1];
    cand_t c2 [N2];
    cand_t c3 [N3];
    cand_t c4 [N4];
    cand_t c5 [1];

    npc_dist_stage #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_rgb   (s_pixel_argb[23:0]),
        .out_valid(v1),
        .out_ready(r1),
        .out_cand (c1)
    );

    npc_min_stage #(.IN_N(N1), .LEVELS(2)) u_min1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v1), .in_ready(r1), .in_cand(c1),
        .out_valid(v2), .out_ready(r2), .out_cand(c2)
    );

    npc_min_stage #(.IN_N(N2), .LEVELS(2)) u_min2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v2), .in_ready(r2), .in_cand(c2),
        .out_valid(v3), .out_ready(r3), .out_cand(c3)
    );

    npc_min_stage #(.IN_N(N3), .LEVELS(2)) u_min3 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v3), .in_ready(r3), .in_cand(c3),
        .out_valid(v4), .out_ready(r4), .out_cand(c4)
    );

    npc_min_stage #(.IN_N(N4), .LEVELS(1)) u_min4 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v4), .in_ready(r4), .in_cand(c4),
        .out_valid(m_valid), .out_ready(m_ready), .out_cand(c5)
    );

    assign m_palette_index = c5[0].idx;

endmodule

// ----- sv/npc_dist_stage.sv -----
// First pipeline stage: squared RGB distance from the pixel to every palette slot.
// Depends on npc_pkg.
module npc_dist_stage
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] in_rgb,
    output logic        out_valid,
    input  logic        out_ready,
    output cand_t       out_cand [ROM_SLOTS]
);

    logic  valid_reg;
    cand_t cand_reg  [ROM_SLOTS];
    cand_t cand_next [ROM_SLOTS];

    always_comb begin
        logic [23:0]         rgb;
        logic [BYTE_W-1:0]   dr, dg, db;
        logic [2*BYTE_W-1:0] sr, sg, sb;
        for (int i = 0; i < ROM_SLOTS; i++) begin
            rgb = palette_rgb(IDX_W'(i));
            dr  = abs_diff(rgb[23:16], in_rgb[23:16]);
            dg  = abs_diff(rgb[15:8],  in_rgb[15:8]);
            db  = abs_diff(rgb[7:0],   in_rgb[7:0]);
            sr  = dr * dr;
            sg  = dg * dg;
            sb  = db * db;
            cand_next[i].idx = IDX_W'(i);
            // Slots outside the configured palette carry a distance no real entry reaches.
            if (i < PALETTE_ENTRIES) begin
                cand_next[i].sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
            end else begin
                cand_next[i].sq_dist = DIST_PAD;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cand  = cand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cand_reg <= cand_next;
        end
    end

endmodule

// ----- sv/npc_min_stage.sv -----
// One registered stage of the minimum-distance tree: LEVELS pairwise compare levels.
// Depends on npc_pkg.
module npc_min_stage
    import npc_pkg::*;
#(
    parameter int IN_N   = 4,
    parameter int LEVELS = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cand_t in_cand  [IN_N],
    output logic  out_valid,
    input  logic  out_ready,
    output cand_t out_cand [IN_N >> LEVELS]
);

    localparam int OUT_N = IN_N >> LEVELS;

    logic  valid_reg;
    cand_t cand_reg [OUT_N];
    cand_t work     [LEVELS+1][IN_N];

    // Even positions always hold the lower indices, so ties keep the lower one.
    always_comb begin
        for (int l = 0; l <= LEVELS; l++) begin
            for (int j = 0; j < IN_N; j++) begin
                work[l][j] = '0;
            end
        end
        for (int j = 0; j < IN_N; j++) begin
            work[0][j] = in_cand[j];
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int j = 0; j < (IN_N >> (l + 1)); j++) begin
                work[l+1][j] = pick_closer(work[l][2*j], work[l][2*j+1]);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cand  = cand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            for (int j = 0; j < OUT_N; j++) begin
                cand_reg[j] <= work[LEVELS][j];
            end
        end
    end

endmodule

// ----- sv/npc_checker.sv -----
// Port-level checker for nearest_palette_color, bound to every instance of it.
// Depends on npc_pkg and nearest_palette_color_assert.svh.
`include "nearest_palette_color_assert.svh"

module npc_checker
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [IDX_W-1:0] m_palette_index
);

    localparam int          DEPTH = 5;
    localparam logic [3:0]  DEPTH_CNT = 4'(DEPTH);
    localparam logic [7:0]  ENTRIES_CNT = 8'(PALETTE_ENTRIES);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_acc && !out_acc) begin
            pending_next = pending_reg + 4'd1;
        end else if (out_acc && !in_acc) begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A held result keeps its value until taken.
    `NPC_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_palette_index))
    // Every result answers an earlier request, and the pipeline never holds more than it has stages.
    `NPC_ASSERT_SAME(a_no_phantom, m_valid, pending_reg != 4'd0 && pending_reg <= DEPTH_CNT)
    // The input side stalls only when the result side is full and blocked.
    `NPC_ASSERT_SAME(a_stall_cause, !s_ready, m_valid && !m_ready)
    // The index always names a configured palette entry.
    `NPC_ASSERT_SAME(a_index_range, m_valid, {1'b0, m_palette_index} < ENTRIES_CNT)

endmodule

bind nearest_palette_color npc_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_palette_index(m_palette_index)
);

// ----- dv/tb.sv -----
// Self-checking testbench for nearest_palette_color: pixels go in on a valid/ready stream,
// and each returned palette index is checked against a local nearest-color search.
// Depends on npc_pkg and the nearest_palette_color RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int PAL_ENTRIES  = PALETTE_ENTRIES_DEFAULT;
    localparam int LISTED       = 80;
    localparam int RANDOM_ITEMS = 930;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int DIR_N        = 21;
    localparam int MAX_REPORTS  = 10;

    // Palette as 0xRRGGBB; slots past the listed ones are black.
    localparam logic [23:0] PAL_RGB [0:LISTED-1] = '{
        24'h020406, 24'h223060, 24'h862a5a, 24'h048c5a,
        24'hb0583c, 24'h645c54, 24'hc8cace, 24'hfff4ec,
        24'hff0c5a, 24'hffa80c, 24'hffee30, 24'h0ce840,
        24'h30b4ff, 24'h8a7ca4, 24'hff7eb0, 24'hffd2b0,
        24'h2e1c18, 24'h16243c, 24'h48263c, 24'h185a60,
        24'h7c3630, 24'h503a42, 24'ha88e80, 24'hf6f288,
        24'hc61a5c, 24'hff742c, 24'hb0ec38, 24'h04bc50,
        24'h0c60be, 24'h7c4e6e, 24'hff7860, 24'hffa48c,
        24'hd0d058, 24'ha0a840, 24'h708028, 24'h405010,
        24'h332c50, 24'h46878f, 24'h94e344, 24'he2f3e4,
        24'h211e20, 24'h555568, 24'ha0a08b, 24'he9efec,
        24'h7c3f58, 24'heb6b6f, 24'hf9a875, 24'hfff6d3,
        24'hc2c630, 24'h3fa130, 24'h4e5817, 24'h342b19,
        24'hffd37b, 24'he18734, 24'hc34e29, 24'h634805,
        24'hc13d95, 24'h8d1523, 24'hffffff, 24'hadadcb,
        24'h596e78, 24'h72b3ff, 24'h3d65b6, 24'h244449,
        24'h2b120d, 24'h9f1211, 24'hfc1400, 24'hfc6a00,
        24'hfcfc00, 24'h9c0c9c, 24'hff099d, 24'h00072c,
        24'h0000ff, 24'h67cdfc, 24'h004849, 24'h00c908,
        24'h52ff00, 24'had5950, 24'hfcb448, 24'hddd9e6
    };

    typedef struct {
        logic [31:0]      pixel;
        bit               known;
        logic [IDX_W-1:0] idx;
    } pixel_row_t;

    typedef struct {
        logic [31:0]      pixel;
        logic [IDX_W-1:0] idx;
    } pending_idx_t;

    // Rows marked known carry an index that can be read off the palette directly.
    pixel_row_t dir_rows [DIR_N] = '{
        '{32'h00000000, 1'b1, 7'd0},
        '{32'hff000000, 1'b1, 7'd0},
        '{32'hffffffff, 1'b1, 7'd58},
        '{32'h00ffffff, 1'b1, 7'd58},
        '{32'h000000ff, 1'b1, 7'd72},
        '{32'h00ff0000, 1'b0, 7'd0},
        '{32'h0000ff00, 1'b0, 7'd0},
        '{32'h80808080, 1'b0, 7'd0},
        '{32'h7f7f7f7f, 1'b0, 7'd0},
        '{32'h00223060, 1'b1, 7'd1},
        '{32'h00ddd9e6, 1'b1, 7'd79},
        '{32'h00020406, 1'b1, 7'd0},
        // Equally far from two entries that differ only in green: the lower one wins.
        '{32'h00fc3f00, 1'b1, 7'd66},
        '{32'h5afc3f00, 1'b1, 7'd66},
        '{32'h00fc6a00, 1'b1, 7'd67},
        '{32'haa555555, 1'b0, 7'd0},
        '{32'h55aaaaaa, 1'b0, 7'd0},
        '{32'h00ffff00, 1'b0, 7'd0},
        '{32'h00ff00ff, 1'b0, 7'd0},
        '{32'h0000ffff, 1'b0, 7'd0},
        '{32'h00010203, 1'b0, 7'd0}
    };

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [31:0]      s_pixel_argb = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [IDX_W-1:0] m_palette_index;

    pending_idx_t expected_idx_q [$];
    int           fail_cnt  = 0;
    int           cycle_cnt = 0;
    bit           tx_calm   = 1'b0;
    bit           rx_calm   = 1'b0;

    nearest_palette_color #(
        .PALETTE_ENTRIES(PAL_ENTRIES)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_argb    (s_pixel_argb),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_idx_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Full search over the palette; only a strictly smaller distance replaces the best.
    function automatic logic [IDX_W-1:0] nearest_index(input logic [31:0] pixel);
        int          n;
        int          best;
        int          best_dist;
        int          dist_sq;
        int          dr;
        int          dg;
        int          db;
        logic [23:0] rgb;
        n = PAL_ENTRIES;
        if (n < 0) n = 0;
        if (n > ROM_SLOTS) n = ROM_SLOTS;
        best      = 0;
        best_dist = 256 * 256 * 4;
        for (int i = 0; i < n; i++) begin
            rgb     = (i < LISTED) ? PAL_RGB[i] : 24'h000000;
            dr      = int'(rgb[23:16]) - int'(pixel[23:16]);
            dg      = int'(rgb[15:8])  - int'(pixel[15:8]);
            db      = int'(rgb[7:0])   - int'(pixel[7:0]);
            dist_sq = dr * dr + dg * dg + db * db;
            if (dist_sq < best_dist) begin
                best_dist = dist_sq;
                best      = i;
            end
        end
        return best[IDX_W-1:0];
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Mix of uniform pixels, exact palette colors, near misses and points halfway
    // between two entries, where ties and close calls live.
    function automatic logic [31:0] draw_pixel();
        int          kind;
        logic [23:0] a;
        logic [23:0] b;
        logic [7:0]  alpha;
        logic [8:0]  sum;
        logic [23:0] rgb;
        kind  = $urandom_range(0, 99);
        alpha = 8'($urandom_range(0, 255));
        a     = PAL_RGB[$urandom_range(0, LISTED - 1)];
        b     = PAL_RGB[$urandom_range(0, LISTED - 1)];
        if (kind < 40) begin
            return $urandom;
        end else if (kind < 65) begin
            rgb = a;
        end else if (kind < 85) begin
            rgb = {nudge(a[23:16], 3), nudge(a[15:8], 3), nudge(a[7:0], 3)};
        end else begin
            for (int c = 0; c < 3; c++) begin
                sum = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]}
                      + 9'($urandom_range(0, 1));
                rgb[c*8 +: 8] = nudge(sum[8:1], $urandom_range(0, 1));
            end
        end
        return {alpha, rgb};
    endfunction

    task automatic send_pixel(input logic [31:0] pixel, input bit known,
                              input logic [IDX_W-1:0] idx);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid      <= 1'b0;
            s_pixel_argb <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_argb <= pixel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_idx_q.push_back('{pixel, known ? idx : nearest_index(pixel)});
    endtask

    initial begin : result_side
        int               stall;
        int               seen;
        pending_idx_t     want;
        seen = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (seen % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            seen++;
            if (expected_idx_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("unexpected result: index %0d with no request pending",
                             m_palette_index);
            end else begin
                want = expected_idx_q.pop_front();
                if (m_palette_index !== want.idx) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("mismatch for pixel %08h: expected index %0d, got %0d",
                                 want.pixel, want.idx, m_palette_index);
                end
            end
        end
    end

    initial begin : request_side
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_N; r++)
            send_pixel(dir_rows[r].pixel, dir_rows[r].known, dir_rows[r].idx);

        // Let the pipeline drain completely before the random traffic starts.
        s_valid <= 1'b0;
        while (expected_idx_q.size() != 0) @(posedge aclk);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            if (k == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                while (expected_idx_q.size() != 0) @(posedge aclk);
            end
            send_pixel(draw_pixel(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_idx_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0 && expected_idx_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/npc_pkg.sv
sv/npc_dist_stage.sv
sv/npc_min_stage.sv
sv/nearest_palette_color.sv
sv/npc_checker.sv
dv/tb.sv
